>>> rtl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values and shared types.
// ----------------------------------------------------------------------------
`default_nettype none
package sha256_pkg;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } back_state_t;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

endpackage
`default_nettype wire

>>> rtl/sha256_fifo.sv
// ----------------------------------------------------------------------------
// SHA-256 request queue
// Short queue between the input front and the compression back end.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sha256_pkg::req_t  in_req,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output sha256_pkg::req_t       out_req
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sha256_pkg::req_t     mem [DEPTH];
  logic [AW-1:0]        wr_ptr;
  logic [AW-1:0]        rd_ptr;
  logic [AW:0]          count;
  logic                 push;
  logic                 pop;

  assign in_ready  = (count != (AW+1)'(DEPTH));
  assign out_valid = (count != '0);
  assign out_req   = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

>>> rtl/sha256_core.sv
// ----------------------------------------------------------------------------
// SHA-256 back end
// Packs bytes, pads, runs one round per cycle and emits the digest.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire sha256_pkg::req_t  req,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [31:0]            digest_word,
  output logic [2:0]             word_index,
  output logic                   last_word
);
  sha256_pkg::back_state_t state, state_next;

  logic [31:0] hash   [8];
  logic [31:0] w      [16];
  logic [31:0] v      [8];
  logic [63:0] bit_counter;
  logic [5:0]  round;
  logic        finishing;
  logic        need_len;
  logic [2:0]  emit_idx;

  logic [5:0]  pos;
  logic        take;
  logic [31:0] s0, s1, w_new, t1, t2, ch, maj, e_sig, a_sig;

  assign pos = bit_counter[8:3];

  assign req_ready = (state == sha256_pkg::ST_IDLE);
  assign take      = req_valid && req_ready;

  assign s0    = {w[1][6:0], w[1][31:7]} ^ {w[1][17:0], w[1][31:18]} ^ (w[1] >> 3);
  assign s1    = {w[14][16:0], w[14][31:17]} ^ {w[14][18:0], w[14][31:19]}
                 ^ (w[14] >> 10);
  assign w_new = w[0] + s0 + w[9] + s1;
  assign e_sig = {v[4][5:0], v[4][31:6]} ^ {v[4][10:0], v[4][31:11]}
                 ^ {v[4][24:0], v[4][31:25]};
  assign a_sig = {v[0][1:0], v[0][31:2]} ^ {v[0][12:0], v[0][31:13]}
                 ^ {v[0][21:0], v[0][31:22]};
  assign ch    = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign maj   = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t1    = v[7] + e_sig + ch + sha256_pkg::ROUND_K[round] + w[0];
  assign t2    = a_sig + maj;

  always_comb begin
    state_next = state;
    unique case (state)
      sha256_pkg::ST_IDLE: begin
        if (take && req.present && (pos == 6'd63)) begin
          state_next = sha256_pkg::ST_ROUND;
        end else if (take && req.last) begin
          state_next = sha256_pkg::ST_ROUND;
        end
      end
      sha256_pkg::ST_ROUND: begin
        if (round == 6'd63) begin
          state_next = sha256_pkg::ST_FOLD;
        end
      end
      sha256_pkg::ST_FOLD: begin
        if (need_len) begin
          state_next = sha256_pkg::ST_ROUND;
        end else if (finishing) begin
          state_next = sha256_pkg::ST_EMIT;
        end else begin
          state_next = sha256_pkg::ST_IDLE;
        end
      end
      sha256_pkg::ST_EMIT: begin
        if (out_ready && (emit_idx == 3'd7)) begin
          state_next = sha256_pkg::ST_IDLE;
        end
      end
      default: state_next = sha256_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid   = (state == sha256_pkg::ST_EMIT);
    digest_word = hash[emit_idx];
    word_index  = emit_idx;
    last_word   = (emit_idx == 3'd7);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha256_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // payload and control registers
  always_ff @(posedge clk) begin
    logic [63:0] cnt;
    logic [5:0]  p;
    logic [31:0] blk [16];
    logic        fire;
    logic        two;
    if (rst) begin
      for (int i = 0; i < 8; i++) hash[i] <= sha256_pkg::INIT_HASH[i];
      bit_counter <= '0;
      round       <= '0;
      finishing   <= 1'b0;
      need_len    <= 1'b0;
      emit_idx    <= '0;
    end else begin
      unique case (state)
        sha256_pkg::ST_IDLE: begin
          if (take) begin
            cnt  = bit_counter;
            blk  = w;
            fire = 1'b0;
            two  = 1'b0;
            if (req.present) begin
              p = cnt[8:3];
              blk[p[5:2]][8*(3-p[1:0]) +: 8] = req.data;
              cnt = cnt + 64'd8;
              fire = (p == 6'd63);
            end
            if (req.last && !fire) begin
              p = cnt[8:3];
              blk[p[5:2]][8*(3-p[1:0]) +: 8] = sha256_pkg::PAD_BYTE;
              for (int i = 0; i < 16; i++) begin
                if (4'(i) > p[5:2]) blk[i] = '0;
              end
              for (int b = 0; b < 4; b++) begin
                if (2'(b) > p[1:0]) blk[p[5:2]][8*(3-b) +: 8] = '0;
              end
              if (p < 6'd56) begin
                blk[14] = cnt[63:32];
                blk[15] = cnt[31:0];
              end else begin
                two = 1'b1;
              end
            end
            w           <= blk;
            bit_counter <= cnt;
            finishing   <= req.last;
            need_len    <= two || (fire && req.last);
            round       <= '0;
            for (int i = 0; i < 8; i++) v[i] <= hash[i];
          end
        end
        sha256_pkg::ST_ROUND: begin
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= w_new;
          v[7] <= v[6];
          v[6] <= v[5];
          v[5] <= v[4];
          v[4] <= v[3] + t1;
          v[3] <= v[2];
          v[2] <= v[1];
          v[1] <= v[0];
          v[0] <= t1 + t2;
          round <= round + 6'd1;
        end
        sha256_pkg::ST_FOLD: begin
          for (int i = 0; i < 8; i++) begin
            hash[i] <= hash[i] + v[i];
            v[i]    <= hash[i] + v[i];
          end
          round <= '0;
          if (need_len) begin
            // length block: pad byte already placed unless block ended exactly
            for (int i = 1; i < 14; i++) w[i] <= '0;
            w[0]     <= (bit_counter[8:3] == 6'd0) ? {sha256_pkg::PAD_BYTE, 24'd0} : '0;
            w[14]    <= bit_counter[63:32];
            w[15]    <= bit_counter[31:0];
            need_len <= 1'b0;
          end
          emit_idx <= '0;
        end
        sha256_pkg::ST_EMIT: begin
          if (out_ready) begin
            emit_idx <= emit_idx + 3'd1;
            if (emit_idx == 3'd7) begin
              for (int i = 0; i < 8; i++) hash[i] <= sha256_pkg::INIT_HASH[i];
              bit_counter <= '0;
              finishing   <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> rtl/sha256_message_digest.sv
// ----------------------------------------------------------------------------
// SHA-256 message digest
// Byte-stream SHA-256 with padding and eight-word digest output.
// ----------------------------------------------------------------------------
// Input channel (valid/ready): msg_byte, byte_present, end_of_message.
// Requests enter a queue of QUEUE_DEPTH entries (four by default), so the
// source is not held while the back end compresses, unless the queue fills.
// Output channel (valid/ready): eight digest words, word_index 0..7,
// last_word on the eighth.
// A byte that does not fill a block is only packed; the back end stays idle.
// A byte that fills a block runs 64 rounds of the single round unit, one
// fold and one return to idle, taking no request meanwhile. End of message
// adds one or two blocks of 64 rounds and one fold each, then eight words.
// While the receiver stalls, the current digest word holds and the back end
// takes no request; the queue goes on accepting until full.
// Reset (rst, synchronous) loads the initial hash and clears the length.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_message_digest #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  msg_byte,
  input  wire logic        byte_present,
  input  wire logic        end_of_message,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word
);
  sha256_pkg::req_t in_req, q_req;
  logic             q_valid, q_ready;

  always_comb begin
    in_req.data    = msg_byte;
    in_req.present = byte_present;
    in_req.last    = end_of_message;
  end

  sha256_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
    .out_valid(q_valid), .out_ready(q_ready), .out_req(q_req)
  );

  sha256_core u_core (
    .clk(clk), .rst(rst),
    .req_valid(q_valid), .req_ready(q_ready), .req(q_req),
    .out_valid(out_valid), .out_ready(out_ready),
    .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
  );
endmodule
`default_nettype wire
